### src/aerr_pkg.sv
package aerr_pkg;

    // Grid and list geometry
    localparam int GRID_SIDE   = 64;
    localparam int COORD_W     = 7;
    localparam int CELL_AW     = 12;
    localparam int CELL_DEPTH  = 4096;
    localparam int MAX_REGIONS = 2731;
    localparam int RIDX_W      = 12;
    localparam int BOX_W       = 4 * COORD_W;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 45;
    localparam int CNT_W       = 13;
    localparam logic [VAL_W-1:0] ERR_INF = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REFINE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_CLR, S_UPD, S_RD, S_RDW,
        S_GINIT, S_GSCAN, S_GDRAIN, S_GRES, S_GDIV, S_WSTART,
        S_WLOOP, S_WBLD, S_WCHK, S_BSCAN, S_BDRAIN, S_BCHK,
        S_RSCAN, S_RDRAIN, S_BDIV0, S_BDIV, S_DECIDE,
        S_REM1, S_REM2, S_REM3, S_REM4, S_SPL1, S_SPL2, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_ZERO, RES_INF, RES_CELL, RES_MX, RES_DIV
    } res_sel_t;

    typedef enum logic [1:0] {
        SCAN_GRID, SCAN_BOX, SCAN_RAISE
    } scan_mode_t;

    typedef enum logic [1:0] {
        BRD_IDX, BRD_NLAST, BRD_CLAST
    } brd_sel_t;

    typedef enum logic [1:0] {
        BWR_IDX_A, BWR_N_B, BWR_IDX_LO, BWR_CNT_HI
    } bwr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     clr_step;
        logic     cell_upd;
        logic     cell_rd_pt;
        logic     scan_init_grid;
        logic     scan_init_box;
        logic     scan_init_raise;
        logic     scan_step;
        logic     div_start;
        logic     div_box;
        logic     res_load;
        res_sel_t res_sel;
        logic     idx_init;
        logic     idx_inc;
        logic     box_rd;
        brd_sel_t box_rd_sel;
        logic     n_dec;
        logic     latch_a;
        logic     latch_b;
        logic     box_wr;
        bwr_sel_t box_wr_sel;
        logic     count_dec;
        logic     count_inc;
        logic     out_load;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic g_empty;
        logic clr_last;
        logic scan_last;
        logic box_empty;
        logic mx_gt_th;
        logic cnt_zero;
        logic th_zero;
        logic idx_ge_n;
        logic avg_gt_lim;
        logic remove_ok;
        logic list_full;
        logic div_idle;
        logic out_busy;
    } stat_t;

endpackage

### src/adaptive_error_region_refiner.sv
// Adaptive error region refiner.
// Input channel s_*: one command per transfer (clear, update cell, refine,
// read cell) with its coordinates, value and threshold. Result channel m_*:
// exactly one result_value per command. grid_width / grid_height are written
// through cfg_wr_en / cfg_index / cfg_data, by the user only while the block
// is idle; the block itself does not enforce this. Commands run one at a
// time; the grid is a single-port-write memory read once per cycle, so cost
// follows memory accesses: clear writes all 4096 cells, one cell a cycle;
// refine scans the grid and divides, then per region scans the box (again
// to raise its cells when its maximum exceeds the threshold) and divides.
// The result sits in an output register; a new command is accepted while it
// waits. If m_ready stays low with the register full, the next result waits
// in its final step and s_ready stays low until the register frees up.
// After reset the block sets every cell to infinity (s_ready low);
// configuration writes are accepted during that pass.
module adaptive_error_region_refiner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_task_x,
    input  logic [5:0]  s_task_y,
    input  logic [31:0] s_error_value,
    input  logic [31:0] s_threshold,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value
);

    aerr_pkg::ctrl_t ctrl;
    aerr_pkg::stat_t stat;

    aerr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    aerr_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_task_x       (s_task_x),
        .s_task_y       (s_task_y),
        .s_error_value  (s_error_value),
        .s_threshold    (s_threshold),
        .m_valid        (m_valid),
        .m_result_value (m_result_value),
        .m_ready        (m_ready)
    );

endmodule

### src/aerr_div.sv
// Restoring divider, one quotient bit per cycle; saturated sums or a zero divisor give infinity
module aerr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [aerr_pkg::SUM_W-1:0]        num,
    input  logic [aerr_pkg::CNT_W-1:0]        den,
    output logic                              busy,
    output logic [aerr_pkg::VAL_W-1:0]        quo
);

    logic                        busy_reg, busy_next;
    logic [4:0]                  step_reg, step_next;
    logic [aerr_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [aerr_pkg::CNT_W-1:0]  den_reg, den_next;
    logic [aerr_pkg::VAL_W-1:0]  quo_reg, quo_next;
    logic [aerr_pkg::CNT_W:0]    trial;
    logic                        ge;

    assign trial = {rem_reg, quo_reg[aerr_pkg::VAL_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (num >= {13'd0, aerr_pkg::ERR_INF} || den == '0) begin
                quo_next  = aerr_pkg::ERR_INF;
                busy_next = 1'b0;
            end else begin
                quo_next  = num[aerr_pkg::VAL_W-1:0];
                rem_next  = '0;
                den_next  = den;
                step_next = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next  = ge ? aerr_pkg::CNT_W'(trial - {1'b0, den_reg})
                           : trial[aerr_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[aerr_pkg::VAL_W-2:0], ge};
            step_next = step_reg + 5'd1;
            if (&step_reg) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

### src/aerr_datapath.sv
// Grid memory, region list, scan accumulators and result register
module aerr_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  aerr_pkg::ctrl_t             ctrl,
    output aerr_pkg::stat_t             stat,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [6:0]                  cfg_data,
    input  logic [5:0]                  s_task_x,
    input  logic [5:0]                  s_task_y,
    input  logic [31:0]                 s_error_value,
    input  logic [31:0]                 s_threshold,
    output logic                        m_valid,
    output logic [31:0]                 m_result_value,
    input  logic                        m_ready
);

    localparam int CW = aerr_pkg::COORD_W;
    localparam int VW = aerr_pkg::VAL_W;
    localparam int RW = aerr_pkg::RIDX_W;
    localparam int BW = aerr_pkg::BOX_W;

    // Configuration and latched item
    logic [CW-1:0] gw_reg, gh_reg;
    logic [5:0]    tx_reg, ty_reg;
    logic [VW-1:0] val_reg, th_reg;

    // Memories
    logic [VW-1:0] cell_mem [aerr_pkg::CELL_DEPTH];
    logic [VW-1:0] cell_q_reg;
    logic [BW-1:0] box_mem [aerr_pkg::MAX_REGIONS];
    logic [BW-1:0] box_q_reg;

    // Scan state
    logic [CW-1:0] blx_reg, bly_reg, bux_reg, buy_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    aerr_pkg::scan_mode_t mode_reg;
    logic          pend_reg;
    logic [aerr_pkg::CELL_AW-1:0] addr_d_reg, clr_cnt_reg;
    logic [aerr_pkg::SUM_W-1:0]   sum_reg;
    logic [VW-1:0]                mx_reg;
    logic [aerr_pkg::CNT_W-1:0]   cnt_reg;

    // Region walk
    logic [RW-1:0] idx_reg, n_reg, count_reg;
    logic [BW-1:0] a_reg, b_reg;
    logic [VW-1:0] res_reg, out_data_reg;
    logic          out_valid_reg;

    logic                  in_grid;
    logic [VW-1:0]         min_err, raise_val;
    logic                  cell_we;
    logic [aerr_pkg::CELL_AW-1:0] cell_wa, cell_ra;
    logic [VW-1:0]         cell_wd;
    logic                  box_we;
    logic [RW-1:0]         box_wa, box_ra;
    logic [BW-1:0]         box_wd, box_lo, box_hi;
    logic [CW-1:0]         sx, sy, split;
    logic [aerr_pkg::CNT_W-1:0] area;
    logic                  div_busy;
    logic [VW-1:0]         div_quo;
    logic [6:0]            cfg_clamped;

    assign in_grid = ({1'b0, tx_reg} < gw_reg) && ({1'b0, ty_reg} < gh_reg);
    assign min_err = (th_reg == aerr_pkg::ERR_INF) ? aerr_pkg::ERR_INF : th_reg + 32'd1;
    assign raise_val = (cell_q_reg < min_err) ? min_err : cell_q_reg;
    assign sx   = bux_reg - blx_reg;
    assign sy   = buy_reg - bly_reg;
    assign area = aerr_pkg::CNT_W'(sx) * aerr_pkg::CNT_W'(sy);
    assign cfg_clamped = (cfg_data > 7'd64) ? 7'd64 : cfg_data;

    // Halving of the current box along its longer side (the y side on a tie)
    always_comb begin
        box_lo = {blx_reg, bly_reg, bux_reg, buy_reg};
        box_hi = {blx_reg, bly_reg, bux_reg, buy_reg};
        split  = '0;
        if (sx > sy) begin
            split  = blx_reg + (sx >> 1);
            box_lo = {blx_reg, bly_reg, split, buy_reg};
            box_hi = {split, bly_reg, bux_reg, buy_reg};
        end else begin
            split  = bly_reg + (sy >> 1);
            box_lo = {blx_reg, bly_reg, bux_reg, split};
            box_hi = {blx_reg, split, bux_reg, buy_reg};
        end
    end

    // Cell memory ports
    always_comb begin
        cell_we = 1'b0;
        cell_wa = '0;
        cell_wd = '0;
        if (ctrl.clr_step) begin
            cell_we = 1'b1;
            cell_wa = clr_cnt_reg;
            cell_wd = aerr_pkg::ERR_INF;
        end else if (ctrl.cell_upd && in_grid) begin
            cell_we = 1'b1;
            cell_wa = {ty_reg, tx_reg};
            cell_wd = val_reg;
        end else if (pend_reg && mode_reg == aerr_pkg::SCAN_RAISE) begin
            cell_we = 1'b1;
            cell_wa = addr_d_reg;
            cell_wd = raise_val;
        end
        cell_ra = ctrl.cell_rd_pt ? {ty_reg, tx_reg} : {cy_reg[5:0], cx_reg[5:0]};
    end

    always_ff @(posedge aclk) begin
        if (cell_we) cell_mem[cell_wa] <= cell_wd;
        if (ctrl.cell_rd_pt || ctrl.scan_step) cell_q_reg <= cell_mem[cell_ra];
    end

    // Region memory ports
    always_comb begin
        box_we = 1'b0;
        box_wa = '0;
        box_wd = '0;
        if (ctrl.clr_step && clr_cnt_reg == '0) begin
            box_we = 1'b1;
            box_wd = {7'd0, 7'd0, gw_reg, gh_reg};
        end else if (ctrl.box_wr) begin
            box_we = 1'b1;
            case (ctrl.box_wr_sel)
                aerr_pkg::BWR_IDX_A:  begin box_wa = idx_reg;   box_wd = a_reg;  end
                aerr_pkg::BWR_N_B:    begin box_wa = n_reg;     box_wd = b_reg;  end
                aerr_pkg::BWR_IDX_LO: begin box_wa = idx_reg;   box_wd = box_lo; end
                default:              begin box_wa = count_reg; box_wd = box_hi; end
            endcase
        end
        case (ctrl.box_rd_sel)
            aerr_pkg::BRD_NLAST: box_ra = n_reg - 12'd1;
            aerr_pkg::BRD_CLAST: box_ra = count_reg - 12'd1;
            default:             box_ra = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (box_we) box_mem[box_wa] <= box_wd;
        if (ctrl.box_rd) box_q_reg <= box_mem[box_ra];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg        <= 7'd64;
            gh_reg        <= 7'd64;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= 12'd1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == aerr_pkg::CFG_GRID_WIDTH) gw_reg <= cfg_clamped;
                else gh_reg <= cfg_clamped;
            end
            if (ctrl.clr_step) clr_cnt_reg <= clr_cnt_reg + 12'd1;
            pend_reg <= ctrl.scan_step;
            if (ctrl.clr_step) count_reg <= 12'd1;
            else if (ctrl.count_dec) count_reg <= count_reg - 12'd1;
            else if (ctrl.count_inc) count_reg <= count_reg + 12'd1;
            if (ctrl.out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.latch_in) begin
            tx_reg  <= s_task_x;
            ty_reg  <= s_task_y;
            val_reg <= s_error_value;
            th_reg  <= s_threshold;
        end
        // scan bounds and counters
        if (ctrl.scan_init_grid) begin
            {blx_reg, bly_reg, bux_reg, buy_reg} <= {7'd0, 7'd0, gw_reg, gh_reg};
            cx_reg   <= '0;
            cy_reg   <= '0;
            mode_reg <= aerr_pkg::SCAN_GRID;
        end else if (ctrl.scan_init_box) begin
            {blx_reg, bly_reg, bux_reg, buy_reg} <= box_q_reg;
            cx_reg   <= box_q_reg[BW-1 -: CW];
            cy_reg   <= box_q_reg[BW-CW-1 -: CW];
            mode_reg <= aerr_pkg::SCAN_BOX;
        end else if (ctrl.scan_init_raise) begin
            cx_reg   <= blx_reg;
            cy_reg   <= bly_reg;
            mode_reg <= aerr_pkg::SCAN_RAISE;
        end else if (ctrl.scan_step) begin
            if (cx_reg == bux_reg - 7'd1) begin
                cx_reg <= blx_reg;
                cy_reg <= cy_reg + 7'd1;
            end else begin
                cx_reg <= cx_reg + 7'd1;
            end
        end
        if (ctrl.scan_step) addr_d_reg <= {cy_reg[5:0], cx_reg[5:0]};
        // accumulation in the cycle after the read
        if (ctrl.scan_init_grid || ctrl.scan_init_box) begin
            sum_reg <= '0;
            mx_reg  <= '0;
            cnt_reg <= '0;
        end else if (pend_reg && mode_reg != aerr_pkg::SCAN_RAISE) begin
            if (cell_q_reg > mx_reg) mx_reg <= cell_q_reg;
            if (mode_reg == aerr_pkg::SCAN_BOX || cell_q_reg > th_reg) begin
                sum_reg <= sum_reg + {13'd0, cell_q_reg};
                cnt_reg <= cnt_reg + 13'd1;
            end
        end
        // walk indexes and swap buffers
        if (ctrl.idx_init) begin
            idx_reg <= '0;
            n_reg   <= count_reg;
        end else begin
            if (ctrl.idx_inc) idx_reg <= idx_reg + 12'd1;
            if (ctrl.n_dec) n_reg <= n_reg - 12'd1;
        end
        if (ctrl.latch_a) a_reg <= box_q_reg;
        if (ctrl.latch_b) b_reg <= box_q_reg;
        // result
        if (ctrl.res_load) begin
            case (ctrl.res_sel)
                aerr_pkg::RES_INF:  res_reg <= aerr_pkg::ERR_INF;
                aerr_pkg::RES_CELL: res_reg <= in_grid ? cell_q_reg : aerr_pkg::ERR_INF;
                aerr_pkg::RES_MX:   res_reg <= mx_reg;
                aerr_pkg::RES_DIV:  res_reg <= div_quo;
                default:            res_reg <= '0;
            endcase
        end
        if (ctrl.out_load) out_data_reg <= res_reg;
    end

    aerr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (sum_reg),
        .den     (ctrl.div_box ? area : cnt_reg),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // Status to the controller
    always_comb begin
        stat.g_empty    = (gw_reg == '0) || (gh_reg == '0);
        stat.clr_last   = &clr_cnt_reg;
        stat.scan_last  = (cx_reg == bux_reg - 7'd1) && (cy_reg == buy_reg - 7'd1);
        stat.box_empty  = (blx_reg == bux_reg) || (bly_reg == buy_reg);
        stat.mx_gt_th   = mx_reg > th_reg;
        stat.cnt_zero   = cnt_reg == '0;
        stat.th_zero    = th_reg == '0;
        stat.idx_ge_n   = idx_reg >= n_reg;
        stat.avg_gt_lim = {2'b00, div_quo} > {th_reg, 2'b00};
        stat.remove_ok  = (area <= 13'd2) || !(mx_reg > th_reg);
        stat.list_full  = count_reg >= RW'(aerr_pkg::MAX_REGIONS);
        stat.div_idle   = !div_busy;
        stat.out_busy   = out_valid_reg && !m_ready;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_data_reg;

endmodule

### src/aerr_ctrl.sv
// Command sequencer: clearing pass, cell access, grid scan and region walk
module aerr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  aerr_pkg::stat_t   stat,
    output aerr_pkg::ctrl_t   ctrl
);

    aerr_pkg::state_t state_reg, state_next;
    aerr_pkg::cmd_t   cmd_in;

    assign cmd_in = aerr_pkg::cmd_t'(s_command);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aerr_pkg::S_RCLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aerr_pkg::S_RCLR:   if (stat.clr_last) state_next = aerr_pkg::S_IDLE;
            aerr_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_in)
                        aerr_pkg::CMD_CLEAR:  state_next = aerr_pkg::S_CLR;
                        aerr_pkg::CMD_UPDATE: state_next = aerr_pkg::S_UPD;
                        aerr_pkg::CMD_REFINE: state_next = aerr_pkg::S_GINIT;
                        default:              state_next = aerr_pkg::S_RD;
                    endcase
                end
            end
            aerr_pkg::S_CLR:    if (stat.clr_last) state_next = aerr_pkg::S_DONE;
            aerr_pkg::S_UPD:    state_next = aerr_pkg::S_DONE;
            aerr_pkg::S_RD:     state_next = aerr_pkg::S_RDW;
            aerr_pkg::S_RDW:    state_next = aerr_pkg::S_DONE;
            aerr_pkg::S_GINIT:  state_next = stat.g_empty ? aerr_pkg::S_DONE
                                                          : aerr_pkg::S_GSCAN;
            aerr_pkg::S_GSCAN:  if (stat.scan_last) state_next = aerr_pkg::S_GDRAIN;
            aerr_pkg::S_GDRAIN: state_next = aerr_pkg::S_GRES;
            aerr_pkg::S_GRES:   state_next = stat.cnt_zero ? aerr_pkg::S_WSTART
                                                           : aerr_pkg::S_GDIV;
            aerr_pkg::S_GDIV:   if (stat.div_idle) state_next = aerr_pkg::S_WSTART;
            aerr_pkg::S_WSTART: state_next = stat.th_zero ? aerr_pkg::S_DONE
                                                          : aerr_pkg::S_WLOOP;
            aerr_pkg::S_WLOOP:  state_next = stat.idx_ge_n ? aerr_pkg::S_DONE
                                                           : aerr_pkg::S_WBLD;
            aerr_pkg::S_WBLD:   state_next = aerr_pkg::S_WCHK;
            aerr_pkg::S_WCHK:   state_next = stat.box_empty ? aerr_pkg::S_WLOOP
                                                            : aerr_pkg::S_BSCAN;
            aerr_pkg::S_BSCAN:  if (stat.scan_last) state_next = aerr_pkg::S_BDRAIN;
            aerr_pkg::S_BDRAIN: state_next = aerr_pkg::S_BCHK;
            aerr_pkg::S_BCHK:   state_next = stat.mx_gt_th ? aerr_pkg::S_RSCAN
                                                           : aerr_pkg::S_BDIV0;
            aerr_pkg::S_RSCAN:  if (stat.scan_last) state_next = aerr_pkg::S_RDRAIN;
            aerr_pkg::S_RDRAIN: state_next = aerr_pkg::S_BDIV0;
            aerr_pkg::S_BDIV0:  state_next = aerr_pkg::S_BDIV;
            aerr_pkg::S_BDIV:   if (stat.div_idle) state_next = aerr_pkg::S_DECIDE;
            aerr_pkg::S_DECIDE: begin
                if (stat.avg_gt_lim) state_next = aerr_pkg::S_WLOOP;
                else if (stat.remove_ok) state_next = aerr_pkg::S_REM1;
                else if (stat.list_full) state_next = aerr_pkg::S_WLOOP;
                else state_next = aerr_pkg::S_SPL1;
            end
            aerr_pkg::S_REM1:   state_next = aerr_pkg::S_REM2;
            aerr_pkg::S_REM2:   state_next = aerr_pkg::S_REM3;
            aerr_pkg::S_REM3:   state_next = aerr_pkg::S_REM4;
            aerr_pkg::S_REM4:   state_next = aerr_pkg::S_WLOOP;
            aerr_pkg::S_SPL1:   state_next = aerr_pkg::S_SPL2;
            aerr_pkg::S_SPL2:   state_next = aerr_pkg::S_WLOOP;
            aerr_pkg::S_DONE:   if (!stat.out_busy) state_next = aerr_pkg::S_IDLE;
            default:            state_next = aerr_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        unique case (state_reg) inside
            aerr_pkg::S_RCLR: ctrl.clr_step = 1'b1;
            aerr_pkg::S_IDLE: begin
                s_ready       = 1'b1;
                ctrl.latch_in = s_valid;
            end
            aerr_pkg::S_CLR: begin
                ctrl.clr_step = 1'b1;
                ctrl.res_load = stat.clr_last;
                ctrl.res_sel  = aerr_pkg::RES_ZERO;
            end
            aerr_pkg::S_UPD: begin
                ctrl.cell_upd = 1'b1;
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = aerr_pkg::RES_ZERO;
            end
            aerr_pkg::S_RD:   ctrl.cell_rd_pt = 1'b1;
            aerr_pkg::S_RDW: begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = aerr_pkg::RES_CELL;
            end
            aerr_pkg::S_GINIT: begin
                ctrl.scan_init_grid = !stat.g_empty;
                ctrl.res_load       = stat.g_empty;
                ctrl.res_sel        = aerr_pkg::RES_INF;
            end
            aerr_pkg::S_GSCAN, aerr_pkg::S_BSCAN, aerr_pkg::S_RSCAN:
                ctrl.scan_step = 1'b1;
            aerr_pkg::S_GRES: begin
                ctrl.res_load  = stat.cnt_zero;
                ctrl.res_sel   = aerr_pkg::RES_MX;
                ctrl.div_start = !stat.cnt_zero;
            end
            aerr_pkg::S_GDIV: begin
                ctrl.res_load = stat.div_idle;
                ctrl.res_sel  = aerr_pkg::RES_DIV;
            end
            aerr_pkg::S_WSTART: ctrl.idx_init = 1'b1;
            aerr_pkg::S_WLOOP: begin
                ctrl.box_rd     = 1'b1;
                ctrl.box_rd_sel = aerr_pkg::BRD_IDX;
            end
            aerr_pkg::S_WBLD: ctrl.scan_init_box = 1'b1;
            aerr_pkg::S_WCHK: ctrl.idx_inc = stat.box_empty;
            aerr_pkg::S_BCHK: ctrl.scan_init_raise = stat.mx_gt_th;
            aerr_pkg::S_BDIV0: begin
                ctrl.div_start = 1'b1;
                ctrl.div_box   = 1'b1;
            end
            aerr_pkg::S_DECIDE:
                ctrl.idx_inc = stat.avg_gt_lim || (!stat.remove_ok && stat.list_full);
            aerr_pkg::S_REM1: begin
                ctrl.box_rd     = 1'b1;
                ctrl.box_rd_sel = aerr_pkg::BRD_NLAST;
                ctrl.n_dec      = 1'b1;
            end
            aerr_pkg::S_REM2: begin
                ctrl.latch_a    = 1'b1;
                ctrl.box_rd     = 1'b1;
                ctrl.box_rd_sel = aerr_pkg::BRD_CLAST;
            end
            aerr_pkg::S_REM3: begin
                ctrl.latch_b    = 1'b1;
                ctrl.box_wr     = 1'b1;
                ctrl.box_wr_sel = aerr_pkg::BWR_IDX_A;
            end
            aerr_pkg::S_REM4: begin
                ctrl.box_wr     = 1'b1;
                ctrl.box_wr_sel = aerr_pkg::BWR_N_B;
                ctrl.count_dec  = 1'b1;
            end
            aerr_pkg::S_SPL1: begin
                ctrl.box_wr     = 1'b1;
                ctrl.box_wr_sel = aerr_pkg::BWR_IDX_LO;
            end
            aerr_pkg::S_SPL2: begin
                ctrl.box_wr     = 1'b1;
                ctrl.box_wr_sel = aerr_pkg::BWR_CNT_HI;
                ctrl.count_inc  = 1'b1;
                ctrl.idx_inc    = 1'b1;
            end
            aerr_pkg::S_DONE: ctrl.out_load = !stat.out_busy;
            default: ;
        endcase
    end

endmodule
